// ===== sv/ivrf_pkg.sv =====
// shared types and port decode constants for the indexed video register file
package ivrf_pkg;

  // access kind carried on tuser
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  // default bank depths
  localparam int unsigned CRTC_COUNT_DEF = 25;
  localparam int unsigned SEQ_COUNT_DEF  = 5;
  localparam int unsigned GC_COUNT_DEF   = 9;
  localparam int unsigned ATTR_COUNT_DEF = 21;

  // field widths
  localparam int unsigned PORT_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned AIDX_W = 5;
  localparam int unsigned IN_TDATA_W = 24;

  // i/o port numbers
  localparam logic [PORT_W-1:0] PORT_ATTR_WR  = 16'h03C0;
  localparam logic [PORT_W-1:0] PORT_ATTR_RD  = 16'h03C1;
  localparam logic [PORT_W-1:0] PORT_MISC_WR  = 16'h03C2;
  localparam logic [PORT_W-1:0] PORT_SEQ_IDX  = 16'h03C4;
  localparam logic [PORT_W-1:0] PORT_SEQ_DAT  = 16'h03C5;
  localparam logic [PORT_W-1:0] PORT_MISC_RD  = 16'h03CC;
  localparam logic [PORT_W-1:0] PORT_GC_IDX   = 16'h03CE;
  localparam logic [PORT_W-1:0] PORT_GC_DAT   = 16'h03CF;
  localparam logic [PORT_W-1:0] PORT_CRTC_IDX = 16'h03D4;
  localparam logic [PORT_W-1:0] PORT_CRTC_DAT = 16'h03D5;
  localparam logic [PORT_W-1:0] PORT_STATUS   = 16'h03DA;

  // status bits flipped on every status read
  localparam logic [DATA_W-1:0] STATUS_TOGGLE = 8'h09;
  // attribute index keeps the low five bits of the written byte
  localparam logic [DATA_W-1:0] ATTR_INDEX_MASK = 8'h1F;

endpackage

// ===== sv/indexed_video_register_file_top.sv =====
// top level of the indexed video register file: port decode, register banks and stream handshake
//
// Accepts one i/o port request per clock on the slave stream while the sink keeps taking results
// and returns exactly one result byte per request on the master stream, in order. A request is
// captured in an input register; its port is then decoded, the addressed register is read or
// written and the result byte is captured in an output register once that register is free or
// being drained, so the sustained rate of one request per cycle is set by the single decode
// stage between those two registers. The input register can still take a request while a
// result waits to be taken; backpressure reaches the slave side only when both registers are
// full and the sink stalls. Four indexed banks (crtc, sequencer, graphics, attribute) are
// reached through index and data ports; an index beyond a bank reads zero and drops writes.
// The attribute port alternates index and data writes under a phase flip-flop that a status
// read clears; a status read also flips status bits 0 and 3 and returns the new value. Writes,
// unknown ports and wrong-direction accesses return zero.
module indexed_video_register_file_top #(
  parameter int unsigned CRTC_COUNT = ivrf_pkg::CRTC_COUNT_DEF,  // 1..255
  parameter int unsigned SEQ_COUNT  = ivrf_pkg::SEQ_COUNT_DEF,   // 1..255
  parameter int unsigned GC_COUNT   = ivrf_pkg::GC_COUNT_DEF,    // 1..255
  parameter int unsigned ATTR_COUNT = ivrf_pkg::ATTR_COUNT_DEF   // 1..32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [15:0] port_address, [23:16] write_data
  input  logic [ivrf_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // [0] opcode
  input  logic                                  s_axis_tuser_i,
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [7:0] read_data
  output logic [ivrf_pkg::DATA_W-1:0]           m_axis_tdata_o
);

  import ivrf_pkg::*;

  // index widths into each bank, at least one bit
  localparam int unsigned CRTC_IW = (CRTC_COUNT > 1) ? $clog2(CRTC_COUNT) : 1;
  localparam int unsigned SEQ_IW  = (SEQ_COUNT > 1)  ? $clog2(SEQ_COUNT)  : 1;
  localparam int unsigned GC_IW   = (GC_COUNT > 1)   ? $clog2(GC_COUNT)   : 1;
  localparam int unsigned ATTR_IW = (ATTR_COUNT > 1) ? $clog2(ATTR_COUNT) : 1;

  // input register
  logic              in_valid_q;
  opcode_e           in_op_q;
  logic [PORT_W-1:0] in_port_q;
  logic [DATA_W-1:0] in_wdata_q;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;

  // register file state
  logic [DATA_W-1:0] crtc_q [CRTC_COUNT];
  logic [DATA_W-1:0] seq_q  [SEQ_COUNT];
  logic [DATA_W-1:0] gc_q   [GC_COUNT];
  logic [DATA_W-1:0] attr_q [ATTR_COUNT];
  logic [DATA_W-1:0] crtc_idx_q;
  logic [DATA_W-1:0] seq_idx_q;
  logic [DATA_W-1:0] gc_idx_q;
  logic [AIDX_W-1:0] attr_idx_q;
  logic              attr_phase_q;
  logic [DATA_W-1:0] misc_q;
  logic [DATA_W-1:0] status_q;

  logic              advance;
  logic              in_accept;
  logic              is_wr;
  logic              is_rd;
  logic              crtc_in_range;
  logic              seq_in_range;
  logic              gc_in_range;
  logic              attr_in_range;
  logic [DATA_W-1:0] status_d;
  logic [DATA_W-1:0] rdata_d;

  // the decode stage moves on when the output slot is free or being drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign is_wr = advance && (in_op_q == OP_WRITE);
  assign is_rd = advance && (in_op_q == OP_READ);

  // range checks against each bank depth
  assign crtc_in_range = (32'(crtc_idx_q) < CRTC_COUNT);
  assign seq_in_range  = (32'(seq_idx_q) < SEQ_COUNT);
  assign gc_in_range   = (32'(gc_idx_q) < GC_COUNT);
  assign attr_in_range = (32'(attr_idx_q) < ATTR_COUNT);

  assign status_d = status_q ^ STATUS_TOGGLE;

  // read mux; writes and unknown ports give zero
  always_comb begin
    rdata_d = '0;
    if (in_op_q == OP_READ) begin
      case (in_port_q)
        PORT_ATTR_RD: begin
          if (attr_in_range) rdata_d = attr_q[attr_idx_q[ATTR_IW-1:0]];
        end
        PORT_SEQ_DAT: begin
          if (seq_in_range) rdata_d = seq_q[seq_idx_q[SEQ_IW-1:0]];
        end
        PORT_GC_DAT: begin
          if (gc_in_range) rdata_d = gc_q[gc_idx_q[GC_IW-1:0]];
        end
        PORT_CRTC_DAT: begin
          if (crtc_in_range) rdata_d = crtc_q[crtc_idx_q[CRTC_IW-1:0]];
        end
        PORT_MISC_RD: rdata_d = misc_q;
        PORT_STATUS:  rdata_d = status_d;
        default:      rdata_d = '0;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q    <= opcode_e'(s_axis_tuser_i);
      in_port_q  <= s_axis_tdata_i[PORT_W-1:0];
      in_wdata_q <= s_axis_tdata_i[PORT_W+DATA_W-1:PORT_W];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= rdata_d;
    end
  end

  // single-byte registers and index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crtc_idx_q   <= '0;
      seq_idx_q    <= '0;
      gc_idx_q     <= '0;
      attr_idx_q   <= '0;
      attr_phase_q <= 1'b0;
      misc_q       <= '0;
      status_q     <= '0;
    end else begin
      if (is_wr) begin
        case (in_port_q)
          PORT_ATTR_WR: begin
            // index phase takes the low bits, data phase goes to the bank
            if (!attr_phase_q) attr_idx_q <= AIDX_W'(in_wdata_q & ATTR_INDEX_MASK);
            attr_phase_q <= !attr_phase_q;
          end
          PORT_MISC_WR:  misc_q     <= in_wdata_q;
          PORT_SEQ_IDX:  seq_idx_q  <= in_wdata_q;
          PORT_GC_IDX:   gc_idx_q   <= in_wdata_q;
          PORT_CRTC_IDX: crtc_idx_q <= in_wdata_q;
          default: ;
        endcase
      end
      if (is_rd && (in_port_q == PORT_STATUS)) begin
        // status read resets the attribute flip-flop to expect an index
        attr_phase_q <= 1'b0;
        status_q     <= status_d;
      end
    end
  end

  // indexed banks, writes beyond the depth are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CRTC_COUNT; i++) crtc_q[i] <= '0;
    end else if (is_wr && (in_port_q == PORT_CRTC_DAT) && crtc_in_range) begin
      crtc_q[crtc_idx_q[CRTC_IW-1:0]] <= in_wdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEQ_COUNT; i++) seq_q[i] <= '0;
    end else if (is_wr && (in_port_q == PORT_SEQ_DAT) && seq_in_range) begin
      seq_q[seq_idx_q[SEQ_IW-1:0]] <= in_wdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GC_COUNT; i++) gc_q[i] <= '0;
    end else if (is_wr && (in_port_q == PORT_GC_DAT) && gc_in_range) begin
      gc_q[gc_idx_q[GC_IW-1:0]] <= in_wdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ATTR_COUNT; i++) attr_q[i] <= '0;
    end else if (is_wr && (in_port_q == PORT_ATTR_WR) && attr_phase_q && attr_in_range) begin
      attr_q[attr_idx_q[ATTR_IW-1:0]] <= in_wdata_q;
    end
  end

`ifndef SYNTH
  // a write always returns zero
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_wr |=> (m_axis_tdata_o == '0))
    else $error("write request returned nonzero data");

  // status read leaves the attribute flip-flop expecting an index
  a_status_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_rd && (in_port_q == PORT_STATUS)) |=> !attr_phase_q)
    else $error("attribute phase not cleared by status read");

  // attribute port write flips the phase
  a_attr_phase_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_wr && (in_port_q == PORT_ATTR_WR)) |=> (attr_phase_q != $past(attr_phase_q)))
    else $error("attribute phase did not toggle");

  // backpressure only when both stages are full and the sink stalls
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("request stalled with room in the pipeline");
`endif

endmodule

// ===== bench/tb_top.sv =====
// self-checking stream testbench for the indexed video register file top level
module tb_top;
  import ivrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one i/o port request as the block sees it
  typedef struct packed {
    opcode_e                op;
    logic [PORT_W-1:0]      port;
    logic [DATA_W-1:0]      wdata;
  } io_request_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side, driven by the bench
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [15:0] port_address, [23:16] write_data
  logic [IN_TDATA_W-1:0] s_tdata  = '0;
  // [0] opcode
  logic                  s_tuser  = OP_READ;

  // result side, sampled by the bench
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [7:0] read_data
  logic [DATA_W-1:0]     m_tdata;

  // requests still to send and result bytes still owed by the block
  io_request_t           pending_q[$];
  logic [DATA_W-1:0]     read_data_q[$];

  int unsigned total_requests = 0;
  int unsigned sent_count     = 0;
  int unsigned read_count     = 0;
  int unsigned write_count    = 0;
  int unsigned status_count   = 0;
  int unsigned result_count   = 0;
  int unsigned fail_count     = 0;

  // idle percentages for each side, stepping through three stages of the run
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;

  // shadow copy of the register file
  logic [DATA_W-1:0] crtc_bank [CRTC_COUNT_DEF];
  logic [DATA_W-1:0] seq_bank  [SEQ_COUNT_DEF];
  logic [DATA_W-1:0] gc_bank   [GC_COUNT_DEF];
  logic [DATA_W-1:0] attr_bank [ATTR_COUNT_DEF];
  logic [DATA_W-1:0] crtc_sel;
  logic [DATA_W-1:0] seq_sel;
  logic [DATA_W-1:0] gc_sel;
  logic [AIDX_W-1:0] attr_sel;
  logic              attr_data_phase;
  logic [DATA_W-1:0] misc_q;
  logic [DATA_W-1:0] status_q;

  indexed_video_register_file_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #10 clk_i = ~clk_i;

  // first third: sender mostly busy, receiver stalls a lot; then swapped; then full speed
  always_comb begin
    if (sent_count * 3 < total_requests) begin
      sender_idle_pct   = 7;
      receiver_idle_pct = 49;
    end else if (sent_count * 3 < total_requests * 2) begin
      sender_idle_pct   = 49;
      receiver_idle_pct = 7;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  end

  // applies one request to the shadow registers and returns the byte the block should give back
  function automatic logic [DATA_W-1:0] apply_access(io_request_t req);
    logic [DATA_W-1:0] rd;
    rd = '0;
    if (req.op == OP_WRITE) begin
      case (req.port)
        PORT_ATTR_WR: begin
          // index on the first write, data on the second
          if (!attr_data_phase) begin
            attr_sel = AIDX_W'(req.wdata & ATTR_INDEX_MASK);
          end else if (attr_sel < ATTR_COUNT_DEF) begin
            attr_bank[attr_sel] = req.wdata;
          end
          attr_data_phase = ~attr_data_phase;
        end
        PORT_MISC_WR:  misc_q  = req.wdata;
        PORT_SEQ_IDX:  seq_sel = req.wdata;
        PORT_SEQ_DAT: begin
          if (seq_sel < SEQ_COUNT_DEF) seq_bank[seq_sel] = req.wdata;
        end
        PORT_GC_IDX:   gc_sel = req.wdata;
        PORT_GC_DAT: begin
          if (gc_sel < GC_COUNT_DEF) gc_bank[gc_sel] = req.wdata;
        end
        PORT_CRTC_IDX: crtc_sel = req.wdata;
        PORT_CRTC_DAT: begin
          if (crtc_sel < CRTC_COUNT_DEF) crtc_bank[crtc_sel] = req.wdata;
        end
        default: ;
      endcase
    end else begin
      case (req.port)
        PORT_ATTR_RD:  rd = (attr_sel < ATTR_COUNT_DEF) ? attr_bank[attr_sel] : '0;
        PORT_SEQ_DAT:  rd = (seq_sel < SEQ_COUNT_DEF) ? seq_bank[seq_sel] : '0;
        PORT_GC_DAT:   rd = (gc_sel < GC_COUNT_DEF) ? gc_bank[gc_sel] : '0;
        PORT_CRTC_DAT: rd = (crtc_sel < CRTC_COUNT_DEF) ? crtc_bank[crtc_sel] : '0;
        PORT_MISC_RD:  rd = misc_q;
        PORT_STATUS: begin
          // status read resets the attribute flip-flop and flips the retrace bits
          attr_data_phase = 1'b0;
          status_q        = status_q ^ STATUS_TOGGLE;
          rd              = status_q;
        end
        default: ;
      endcase
    end
    return rd;
  endfunction

  // request driver: predicts on acceptance, then holds or offers the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= OP_READ;
      foreach (crtc_bank[i]) crtc_bank[i] = '0;
      foreach (seq_bank[i])  seq_bank[i]  = '0;
      foreach (gc_bank[i])   gc_bank[i]   = '0;
      foreach (attr_bank[i]) attr_bank[i] = '0;
      crtc_sel        = '0;
      seq_sel         = '0;
      gc_sel          = '0;
      attr_sel        = '0;
      attr_data_phase = 1'b0;
      misc_q          = '0;
      status_q        = '0;
    end else begin
      io_request_t req;
      if (s_tvalid && s_tready) begin
        req = pending_q.pop_front();
        read_data_q.push_back(apply_access(req));
        sent_count++;
        if (req.op == OP_WRITE) write_count++;
        else read_count++;
        if (req.op == OP_READ && req.port == PORT_STATUS) status_count++;
      end
      if (s_tvalid && !s_tready) begin
        // request not taken yet, keep it on the bus
      end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        req      = pending_q[0];
        s_tvalid <= 1'b1;
        s_tdata  <= {req.wdata, req.port};
        s_tuser  <= req.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor: random backpressure and in-order comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      logic [DATA_W-1:0] exp_byte;
      if (m_tvalid === 1'b1 && m_tready) begin
        result_count++;
        if (read_data_q.size() == 0) begin
          $error("read_data: unexpected result %02h with no request outstanding", m_tdata);
          fail_count++;
        end else begin
          exp_byte = read_data_q.pop_front();
          if (m_tdata !== exp_byte) begin
            $error("read_data mismatch: expected %02h, actual %02h", exp_byte, m_tdata);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // queues one request
  task automatic push_req(opcode_e op, logic [PORT_W-1:0] port, logic [DATA_W-1:0] wdata);
    io_request_t req;
    req.op    = op;
    req.port  = port;
    req.wdata = wdata;
    pending_q.push_back(req);
  endtask

  // bank index, mostly in range, sometimes any byte
  function automatic logic [DATA_W-1:0] pick_index(int unsigned depth);
    if ($urandom_range(0, 7) == 0) return DATA_W'($urandom_range(0, 255));
    return DATA_W'($urandom_range(0, depth - 1));
  endfunction

  function automatic opcode_e pick_op();
    return ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
  endfunction

  // select a bank register, then a short run of data accesses to it
  task automatic bank_burst(logic [PORT_W-1:0] idx_port, logic [PORT_W-1:0] dat_port,
                            int unsigned depth);
    int unsigned n;
    n = $urandom_range(1, 4);
    push_req(OP_WRITE, idx_port, pick_index(depth));
    repeat (n) push_req(pick_op(), dat_port, DATA_W'($urandom));
  endtask

  // attribute sequence: optional flip-flop reset, index write, data write, read back
  task automatic attr_burst();
    if ($urandom_range(0, 3) != 0) push_req(OP_READ, PORT_STATUS, DATA_W'($urandom));
    push_req(OP_WRITE, PORT_ATTR_WR, DATA_W'($urandom));
    // now and then a status read lands between index and data
    if ($urandom_range(0, 9) == 0) push_req(OP_READ, PORT_STATUS, DATA_W'($urandom));
    push_req(OP_WRITE, PORT_ATTR_WR, DATA_W'($urandom));
    if ($urandom_range(0, 1) == 1) push_req(OP_READ, PORT_ATTR_RD, DATA_W'($urandom));
  endtask

  // stimulus, reset and end of run
  initial begin
    logic [PORT_W-1:0] known_ports[11];
    logic [PORT_W-1:0] rand_port;
    known_ports = '{PORT_ATTR_WR, PORT_ATTR_RD, PORT_MISC_WR, PORT_SEQ_IDX, PORT_SEQ_DAT,
                    PORT_MISC_RD, PORT_GC_IDX, PORT_GC_DAT, PORT_CRTC_IDX, PORT_CRTC_DAT,
                    PORT_STATUS};

    // directed: reset contents, status toggling, bank edges, attribute flip-flop
    push_req(OP_READ,  PORT_CRTC_DAT, 8'hFF);
    push_req(OP_READ,  PORT_ATTR_RD,  8'h00);
    push_req(OP_READ,  PORT_STATUS,   8'h00);
    push_req(OP_READ,  PORT_STATUS,   8'h00);
    push_req(OP_WRITE, PORT_MISC_WR,  8'hFF);
    push_req(OP_READ,  PORT_MISC_RD,  8'h00);
    push_req(OP_WRITE, PORT_CRTC_IDX, 8'(CRTC_COUNT_DEF - 1));
    push_req(OP_WRITE, PORT_CRTC_DAT, 8'hA5);
    push_req(OP_READ,  PORT_CRTC_DAT, 8'h00);
    // index past the bank: write dropped, read zero
    push_req(OP_WRITE, PORT_CRTC_IDX, 8'hFF);
    push_req(OP_WRITE, PORT_CRTC_DAT, 8'h5A);
    push_req(OP_READ,  PORT_CRTC_DAT, 8'h00);
    push_req(OP_WRITE, PORT_SEQ_IDX,  8'(SEQ_COUNT_DEF - 1));
    push_req(OP_WRITE, PORT_SEQ_DAT,  8'hFF);
    push_req(OP_WRITE, PORT_GC_IDX,   8'(GC_COUNT_DEF));
    push_req(OP_READ,  PORT_GC_DAT,   8'h00);
    // attribute index masked to 0x1f, beyond the bank
    push_req(OP_WRITE, PORT_ATTR_WR,  8'hFF);
    push_req(OP_WRITE, PORT_ATTR_WR,  8'h77);
    push_req(OP_READ,  PORT_ATTR_RD,  8'h00);
    // index written, then status read puts the flip-flop back to index
    push_req(OP_WRITE, PORT_ATTR_WR,  8'hF4);
    push_req(OP_READ,  PORT_STATUS,   8'h00);
    push_req(OP_WRITE, PORT_ATTR_WR,  8'h00);
    push_req(OP_WRITE, PORT_ATTR_WR,  8'hC3);
    push_req(OP_READ,  PORT_ATTR_RD,  8'h00);
    // wrong direction and unknown ports
    push_req(OP_READ,  PORT_ATTR_WR,  8'h00);
    push_req(OP_WRITE, PORT_STATUS,   8'hFF);
    push_req(OP_READ,  16'hFFFF,      8'h00);
    push_req(OP_WRITE, 16'h0000,      8'hFF);

    // random part: mostly well-formed register sequences, some noise
    while (pending_q.size() < 1830) begin
      case ($urandom_range(0, 9))
        0, 1: bank_burst(PORT_CRTC_IDX, PORT_CRTC_DAT, CRTC_COUNT_DEF);
        2:    bank_burst(PORT_SEQ_IDX, PORT_SEQ_DAT, SEQ_COUNT_DEF);
        3:    bank_burst(PORT_GC_IDX, PORT_GC_DAT, GC_COUNT_DEF);
        4, 5: attr_burst();
        6: begin
          push_req(OP_WRITE, PORT_MISC_WR, DATA_W'($urandom));
          push_req(OP_READ,  PORT_MISC_RD, DATA_W'($urandom));
        end
        7:    push_req(OP_READ, PORT_STATUS, DATA_W'($urandom));
        8: begin
          push_req(pick_op(), known_ports[$urandom_range(0, 10)], DATA_W'($urandom));
        end
        default: begin
          // any port, or one close to the decoded range
          if ($urandom_range(0, 1) == 1) rand_port = PORT_W'($urandom);
          else rand_port = PORT_W'($urandom_range(16'h03B0, 16'h03DF));
          push_req(pick_op(), rand_port, DATA_W'($urandom));
        end
      endcase
    end
    total_requests = pending_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: every request taken and every result returned, then a quiet stretch before the report
    while (sent_count != total_requests || read_data_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests: %0d reads (%0d status), %0d writes",
             sent_count, read_count, status_count, write_count);
    $display("%0d results checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) begin
      $display("[indexed_video_register_file_top] OK");
    end else begin
      $display("[indexed_video_register_file_top] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d requests sent, %0d results pending",
             sent_count, total_requests, read_data_q.size());
    $display("[indexed_video_register_file_top] ERROR");
    $finish;
  end

endmodule
